// ===== rtl/qpd_pkg.sv =====
`default_nettype none

package qpd_pkg;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One input byte's worth of output beats, 1 to 3 of them.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       v0;
        logic       msg_end;
    } job_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h46)) ||
            ((c >= 8'h61) && (c <= 8'h66));
        return r;
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] r;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            r = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            r = c - 8'h37;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            r = c - 8'h57;
        end
        else
        begin
            r = 8'h00;
        end
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qpd_front.sv =====
`default_nettype none

module qpd_front
    import qpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       message_end,
    input  wire logic       q_ready,
    output logic            q_push,
    output job_t            q_job
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic [7:0] second_reg;
    logic [7:0] second_next;
    logic       accept;
    logic       b_eq;
    logic       b_lf;
    logic       b_cr;
    logic       b_hex;
    logic       idle_hold;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    assign b_eq  = (in_byte == CH_EQ);
    assign b_lf  = (in_byte == CH_LF);
    assign b_cr  = (in_byte == CH_CR);
    assign b_hex = is_hex(in_byte);
    // '=' with nothing ahead of it opens an escape unless the message ends here
    assign idle_hold = b_eq && !message_end;

    always_comb
    begin
        job_t j;
        j           = '0;
        j.v0        = 1'b1;
        j.msg_end   = message_end;
        pend_next   = pend_reg;
        second_next = second_reg;
        case (pend_reg)
            2'd1:
            begin
                if (b_lf)
                begin
                    pend_next = 2'd0;
                end
                else if ((b_cr || b_hex) && !message_end)
                begin
                    pend_next   = 2'd2;
                    second_next = in_byte;
                end
                else
                begin
                    j.b0 = CH_EQ;
                    if (idle_hold)
                    begin
                        pend_next = 2'd1;
                        j.cnt     = 2'd1;
                    end
                    else
                    begin
                        pend_next = 2'd0;
                        j.b1      = in_byte;
                        j.cnt     = 2'd2;
                    end
                end
            end
            2'd2:
            begin
                if ((second_reg == CH_CR) && b_lf)
                begin
                    pend_next = 2'd0;
                end
                else if ((second_reg != CH_CR) && is_hex(second_reg) && b_hex)
                begin
                    pend_next = 2'd0;
                    j.b0      = {hex_nib(second_reg), hex_nib(in_byte)};
                    j.cnt     = 2'd1;
                end
                else
                begin
                    j.b0 = CH_EQ;
                    j.b1 = second_reg;
                    if (idle_hold)
                    begin
                        pend_next = 2'd1;
                        j.cnt     = 2'd2;
                    end
                    else
                    begin
                        pend_next = 2'd0;
                        j.b2      = in_byte;
                        j.cnt     = 2'd3;
                    end
                end
            end
            default:
            begin
                if (idle_hold)
                begin
                    pend_next = 2'd1;
                end
                else
                begin
                    pend_next = 2'd0;
                    j.b0      = in_byte;
                    j.cnt     = 2'd1;
                end
            end
        endcase
        if (message_end)
        begin
            pend_next   = 2'd0;
            second_next = 8'h00;
            // nothing to show for the last byte: bare end marker
            if (j.cnt == 2'd0)
            begin
                j.cnt = 2'd1;
                j.b0  = 8'h00;
                j.v0  = 1'b0;
            end
        end
        q_job = j;
    end

    assign q_push = accept && (q_job.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 2'd0;
            second_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg   <= pend_next;
            second_reg <= second_next;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && message_end) |=> (pend_reg == 2'd0))
        else $error("pending state survived message end");
    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && message_end) |-> q_push)
        else $error("message end produced no beat");
    a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd2) |-> ((second_reg == CH_CR) || is_hex(second_reg)))
        else $error("held byte is neither CR nor hex");
`endif

endmodule

`default_nettype wire

// ===== rtl/qpd_queue.sv =====
`default_nettype none

module qpd_queue
    import qpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    output logic      push_ready,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count past depth");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (QPTR_W'(wr_reg - rd_reg) == cnt_reg[QPTR_W-1:0]))
        else $error("queue pointers disagree with count");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("beat pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/qpd_back.sv =====
`default_nettype none

module qpd_back
    import qpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  job_t            head_job,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            message_last
);

    logic [1:0] idx_reg;
    logic       ov_reg;
    logic [7:0] byte_reg;
    logic       bv_reg;
    logic       rl_reg;
    logic       ml_reg;
    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    assign load = head_valid && (!ov_reg || out_ready);
    assign last = (idx_reg == (head_job.cnt - 2'd1));
    assign pop  = load && last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head_job.b0;
            2'd1:    sel_byte = head_job.b1;
            default: sel_byte = head_job.b2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ov_reg  <= 1'b1;
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            bv_reg   <= (idx_reg == 2'd0) ? head_job.v0 : 1'b1;
            rl_reg   <= last;
            ml_reg   <= last && head_job.msg_end;
        end
    end

    assign out_valid    = ov_reg;
    assign out_byte     = byte_reg;
    assign byte_valid   = bv_reg;
    assign run_last     = rl_reg;
    assign message_last = ml_reg;

`ifndef SYNTHESIS
    a_idx_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (idx_reg == 2'd0))
        else $error("beat index left mid-run with queue empty");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head_job.cnt))
        else $error("beat index beyond run length");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(byte_valid)))
        else $error("output beat changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/quoted_printable_decoder_top.sv =====
`default_nettype none

// Quoted-printable decoder: takes one encoded byte per beat and returns the
// decoded beats it causes (zero to three). "=XY" with two hex digits of either
// case becomes one byte, "=" CR LF and "=" LF are soft breaks and vanish, any
// other "=" passes through literally. The beat with message_end set flushes
// held bytes and always returns at least one beat (a bare marker with
// byte_valid low if nothing else); its final beat carries message_last.
// Input is taken at one byte per cycle while the queue has room; the output
// side delivers one beat per cycle while out_ready is high. A two- or
// three-beat run always follows input bytes that produced no beat, so while
// out_ready stays high the input is never held off; the four-entry queue
// between the classifier and the beat serializer absorbs the burst.
module quoted_printable_decoder_top
    import qpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       message_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            run_last,
    output logic            message_last
);

    logic q_push;
    logic q_ready;
    logic q_pop;
    logic q_valid;
    job_t push_job;
    job_t head_job;

    qpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .message_end (message_end),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    qpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    qpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (q_valid),
        .head_job     (head_job),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .run_last     (run_last),
        .message_last (message_last)
    );

endmodule

`default_nettype wire
